>>> hw/rtl/rsba_pkg.sv
// ----------------------------------------------------------------------------
// rsba_pkg: shared types and constants of the rotated span blit addresser
// Register map, reset values, configuration bundle and transform result.
// ----------------------------------------------------------------------------
package rsba_pkg;

    // Field widths fixed by the interface
    localparam int RUN_W    = 13;   // run_x, run_y (signed)
    localparam int COLOR_W  = 32;
    localparam int ADDR_W   = 32;
    localparam int QUAD_W   = 2;
    localparam int OFFS_W   = 14;   // offset_x, offset_y (signed)
    localparam int SIZE_W   = 13;   // screen_width, screen_height
    localparam int PITCH_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default run length limit (pixel index wraps after this many pixels)
    localparam int MAX_RUN_DEF = 4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUADRANT      = 3'd0,
        REG_OFFSET_X      = 3'd1,
        REG_OFFSET_Y      = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4,
        REG_LINE_PITCH    = 3'd5,
        REG_FRAME_BASE    = 3'd6
    } t_cfg_reg;

    // Rotation codes
    typedef enum logic [QUAD_W-1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        t_quad                      quadrant;
        logic signed [OFFS_W-1:0]   offset_x;
        logic signed [OFFS_W-1:0]   offset_y;
        logic [SIZE_W-1:0]          screen_width;
        logic [SIZE_W-1:0]          screen_height;
        logic [PITCH_W-1:0]         line_pitch;
        logic [ADDR_W-1:0]          frame_base;
    } t_cfg;

    localparam logic [SIZE_W-1:0]  SCREEN_SIZE_RST = SIZE_W'(240);
    localparam logic [PITCH_W-1:0] LINE_PITCH_RST  = PITCH_W'(240);

    typedef struct packed {
        logic               visible;
        logic [ADDR_W-1:0]  address;
    } t_xform_res;

endpackage

>>> hw/rtl/rsba_xform.sv
// ----------------------------------------------------------------------------
// rsba_xform: pixel rotate, place, clip and address calculation
// Maps one source pixel to its framebuffer word address and visibility.
// ----------------------------------------------------------------------------
module rsba_xform #(
    parameter int IDX_W = 12
) (
    input  rsba_pkg::t_cfg                          i_cfg,
    input  logic signed [rsba_pkg::RUN_W-1:0]       i_run_x,
    input  logic signed [rsba_pkg::RUN_W-1:0]       i_run_y,
    input  logic [IDX_W-1:0]                        i_pixel_index,
    output rsba_pkg::t_xform_res                    o_res
);
    import rsba_pkg::*;

    // Source x needs room for run_x plus the unsigned index
    localparam int SX_W = ((IDX_W + 1 > RUN_W) ? IDX_W + 1 : RUN_W) + 1;
    // Room for negation and the offset add
    localparam int DW   = ((SX_W > OFFS_W) ? SX_W : OFFS_W) + 2;

    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] width_s;
    logic signed [DW-1:0] height_s;
    logic [SIZE_W+PITCH_W-1:0] row_offs;

    assign sx = $signed({{(DW-RUN_W){i_run_x[RUN_W-1]}}, i_run_x})
              + $signed({{(DW-IDX_W){1'b0}}, i_pixel_index});
    assign sy = $signed({{(DW-RUN_W){i_run_y[RUN_W-1]}}, i_run_y});

    always_comb begin
        unique case (i_cfg.quadrant)
            QUAD_0: begin
                rx = sx;
                ry = sy;
            end
            QUAD_90: begin
                rx = sy;
                ry = -sx;
            end
            QUAD_180: begin
                rx = -sx;
                ry = -sy;
            end
            QUAD_270: begin
                rx = -sy;
                ry = sx;
            end
            default: begin
                rx = sx;
                ry = sy;
            end
        endcase
    end

    assign dx = rx + $signed({{(DW-OFFS_W){i_cfg.offset_x[OFFS_W-1]}}, i_cfg.offset_x});
    assign dy = ry + $signed({{(DW-OFFS_W){i_cfg.offset_y[OFFS_W-1]}}, i_cfg.offset_y});

    assign width_s  = $signed({{(DW-SIZE_W){1'b0}}, i_cfg.screen_width});
    assign height_s = $signed({{(DW-SIZE_W){1'b0}}, i_cfg.screen_height});

    // Visible coordinates are below 2^SIZE_W, so the low bits carry them
    assign row_offs = dy[SIZE_W-1:0] * i_cfg.line_pitch;

    assign o_res.visible = !dx[DW-1] && !dy[DW-1] && (dx < width_s) && (dy < height_s);
    assign o_res.address = i_cfg.frame_base
                         + {{(ADDR_W-SIZE_W-PITCH_W){1'b0}}, row_offs}
                         + {{(ADDR_W-SIZE_W){1'b0}}, dx[SIZE_W-1:0]};

endmodule

>>> hw/rtl/rotated_span_blit_addresser.sv
// ----------------------------------------------------------------------------
// rotated_span_blit_addresser: rotated, clipped span blit address generator
// Turns a stream of run pixels into framebuffer word writes.
// ----------------------------------------------------------------------------
// One pixel beat enters per clock while the write side does not stall, and
// its write beat leaves from the result register after passing the two
// register stages (input register, result register) with the rotate, clip
// and row-times-pitch multiply between them. Each input beat is one pixel of
// a horizontal run; the block counts the pixel index inside the run itself,
// restarting after a beat with run_last set or after MAX_RUN pixels. The
// pixel is rotated by the quadrant register, shifted by the offsets and
// clipped exactly against the screen size; a clipped pixel produces no
// output beat. Visible pixels produce address = frame_base + y*pitch + x
// (modulo 2^32) with the color passed through. Write configuration only
// while no pixel is in flight; the config port is always ready.
// ----------------------------------------------------------------------------
module rotated_span_blit_addresser #(
    parameter int MAX_RUN = rsba_pkg::MAX_RUN_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // pixel input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [rsba_pkg::RUN_W-1:0]       i_run_x,
    input  logic signed [rsba_pkg::RUN_W-1:0]       i_run_y,
    input  logic [rsba_pkg::COLOR_W-1:0]            i_pixel_color,
    input  logic                                    i_run_last,
    // write output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [rsba_pkg::ADDR_W-1:0]             o_write_address,
    output logic [rsba_pkg::COLOR_W-1:0]            o_write_color,
    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [rsba_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [rsba_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import rsba_pkg::*;

    localparam int IDX_W = $clog2(MAX_RUN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_RUN - 1);

    // configuration
    t_cfg r_cfg;

    // pixel index counter
    logic [IDX_W-1:0] r_pixel_index;
    logic [IDX_W-1:0] n_pixel_index;

    // input register stage
    logic                       r_in_valid;
    logic signed [RUN_W-1:0]    r_run_x;
    logic signed [RUN_W-1:0]    r_run_y;
    logic [COLOR_W-1:0]         r_color;
    logic [IDX_W-1:0]           r_index;

    // result register stage
    logic                       r_out_valid;
    logic [ADDR_W-1:0]          r_address;
    logic [COLOR_W-1:0]         r_out_color;

    logic       advance;    // result register may load
    logic       in_accept;
    t_xform_res xres;

    // ---------------------------------------------------------------
    // Handshake: the result register loads whenever it is empty or its
    // beat is being taken; the input register takes a new beat whenever
    // it is empty or moving on into the result register.
    // ---------------------------------------------------------------
    assign advance     = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Restart the index after the last pixel of a run or at the length limit
    always_comb begin
        if (i_run_last || r_pixel_index == IDX_LAST) begin
            n_pixel_index = '0;
        end else begin
            n_pixel_index = r_pixel_index + IDX_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quadrant      <= QUAD_0;
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.screen_width  <= SCREEN_SIZE_RST;
            r_cfg.screen_height <= SCREEN_SIZE_RST;
            r_cfg.line_pitch    <= LINE_PITCH_RST;
            r_cfg.frame_base    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_QUADRANT:      r_cfg.quadrant      <= t_quad'(i_cfg_data[QUAD_W-1:0]);
                REG_OFFSET_X:      r_cfg.offset_x      <= i_cfg_data[OFFS_W-1:0];
                REG_OFFSET_Y:      r_cfg.offset_y      <= i_cfg_data[OFFS_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[SIZE_W-1:0];
                REG_LINE_PITCH:    r_cfg.line_pitch    <= i_cfg_data[PITCH_W-1:0];
                REG_FRAME_BASE:    r_cfg.frame_base    <= i_cfg_data[ADDR_W-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register and index counter
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_pixel_index <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (in_accept) begin
                r_pixel_index <= n_pixel_index;
            end
        end
    end

    // Capture the beat together with its index inside the run
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_run_x <= i_run_x;
            r_run_y <= i_run_y;
            r_color <= i_pixel_color;
            r_index <= r_pixel_index;
        end
    end

    // ---------------------------------------------------------------
    // Rotate, place, clip and address
    // ---------------------------------------------------------------
    rsba_xform #(
        .IDX_W          (IDX_W)
    ) u_xform (
        .i_cfg          (r_cfg),
        .i_run_x        (r_run_x),
        .i_run_y        (r_run_y),
        .i_pixel_index  (r_index),
        .o_res          (xres)
    );

    // ---------------------------------------------------------------
    // Result register: only visible pixels become write beats
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && xres.visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_address   <= xres.address;
            r_out_color <= r_color;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_address;
    assign o_write_color   = r_out_color;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_run_last) |=> (r_pixel_index == '0))
        else $error("pixel index did not restart after the last pixel of a run");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_run_last && r_pixel_index != IDX_LAST)
            |=> (r_pixel_index == $past(r_pixel_index) + IDX_W'(1)))
        else $error("pixel index did not advance by one");

    a_index_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_pixel_index))
        else $error("pixel index moved without an accepted beat");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while the pipeline had room");

    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("write beat appeared without a pixel in the input register");

endmodule

>>> tb/tb_rotated_span_blit_addresser.sv
// ----------------------------------------------------------------------------
// tb_rotated_span_blit_addresser: self-checking bench for the span blit addresser
// Streams run pixels under many screen settings and compares every write beat
// against an in-bench model of rotation, offset, clipping and addressing.
// ----------------------------------------------------------------------------

// Predicts the write beats of the addresser and checks the ones it emits
class blit_scoreboard;

    typedef struct packed {
        logic [rsba_pkg::ADDR_W-1:0]  address;
        logic [rsba_pkg::COLOR_W-1:0] color;
    } t_write_beat;

    rsba_pkg::t_quad                       quadrant;
    logic signed [rsba_pkg::OFFS_W-1:0]    offset_x;
    logic signed [rsba_pkg::OFFS_W-1:0]    offset_y;
    logic [rsba_pkg::SIZE_W-1:0]           screen_width;
    logic [rsba_pkg::SIZE_W-1:0]           screen_height;
    logic [rsba_pkg::PITCH_W-1:0]          line_pitch;
    logic [rsba_pkg::ADDR_W-1:0]           frame_base;
    logic [rsba_pkg::RUN_W-1:0]            pixel_index;

    t_write_beat expected_writes[$];
    int          errors;

    function new();
        quadrant      = rsba_pkg::QUAD_0;
        offset_x      = '0;
        offset_y      = '0;
        screen_width  = rsba_pkg::SCREEN_SIZE_RST;
        screen_height = rsba_pkg::SCREEN_SIZE_RST;
        line_pitch    = rsba_pkg::LINE_PITCH_RST;
        frame_base    = '0;
        pixel_index   = '0;
        errors        = 0;
    endfunction

    function void write_reg(logic [rsba_pkg::CFG_IDX_W-1:0] idx,
                            logic [rsba_pkg::CFG_DATA_W-1:0] data);
        case (rsba_pkg::t_cfg_reg'(idx))
            rsba_pkg::REG_QUADRANT:      quadrant      = rsba_pkg::t_quad'(data[1:0]);
            rsba_pkg::REG_OFFSET_X:      offset_x      = data[rsba_pkg::OFFS_W-1:0];
            rsba_pkg::REG_OFFSET_Y:      offset_y      = data[rsba_pkg::OFFS_W-1:0];
            rsba_pkg::REG_SCREEN_WIDTH:  screen_width  = data[rsba_pkg::SIZE_W-1:0];
            rsba_pkg::REG_SCREEN_HEIGHT: screen_height = data[rsba_pkg::SIZE_W-1:0];
            rsba_pkg::REG_LINE_PITCH:    line_pitch    = data[rsba_pkg::PITCH_W-1:0];
            rsba_pkg::REG_FRAME_BASE:    frame_base    = data;
            default: ;
        endcase
    endfunction

    function void note_pixel(logic signed [rsba_pkg::RUN_W-1:0] run_x,
                             logic signed [rsba_pkg::RUN_W-1:0] run_y,
                             logic [rsba_pkg::COLOR_W-1:0] color,
                             logic run_last);
        int          sx;
        int          sy;
        int          dx;
        int          dy;
        int          next_index;
        t_write_beat beat;
        sx = int'(run_x) + int'(pixel_index);
        sy = int'(run_y);
        case (quadrant)
            rsba_pkg::QUAD_0:   begin dx =  sx; dy =  sy; end
            rsba_pkg::QUAD_90:  begin dx =  sy; dy = -sx; end
            rsba_pkg::QUAD_180: begin dx = -sx; dy = -sy; end
            default:            begin dx = -sy; dy =  sx; end
        endcase
        dx = dx + int'(offset_x);
        dy = dy + int'(offset_y);
        if (dx >= 0 && dy >= 0 && dx < int'(screen_width) && dy < int'(screen_height)) begin
            beat.address = frame_base + 32'(dy) * 32'(line_pitch) + 32'(dx);
            beat.color   = color;
            expected_writes.push_back(beat);
        end
        next_index = int'(pixel_index) + 1;
        if (run_last || next_index >= rsba_pkg::MAX_RUN_DEF)
            next_index = 0;
        pixel_index = next_index[rsba_pkg::RUN_W-1:0];
    endfunction

    function void check_write(logic [rsba_pkg::ADDR_W-1:0] address,
                              logic [rsba_pkg::COLOR_W-1:0] color);
        t_write_beat want;
        if (expected_writes.size() == 0) begin
            $error("unexpected write beat: write_address 0x%08h write_color 0x%08h",
                   address, color);
            errors++;
            return;
        end
        want = expected_writes.pop_front();
        if (address !== want.address) begin
            $error("write_address: expected 0x%08h, got 0x%08h", want.address, address);
            errors++;
        end
        if (color !== want.color) begin
            $error("write_color: expected 0x%08h, got 0x%08h", want.color, color);
            errors++;
        end
    endfunction

    function int pending();
        return expected_writes.size();
    endfunction

endclass

module tb_rotated_span_blit_addresser;

    timeunit 1ns;
    timeprecision 1ps;

    import rsba_pkg::*;

    // No register sits at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam int MAX_WAIT       = 6;
    localparam int DRAIN_CYCLES   = 8;     // two-stage pipe plus margin
    localparam int HOLD_CYCLES    = 300;   // long output back-pressure stretch
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat anywhere

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [RUN_W-1:0]   i_run_x;
    logic signed [RUN_W-1:0]   i_run_y;
    logic [COLOR_W-1:0]        i_pixel_color;
    logic                      i_run_last;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ADDR_W-1:0]         o_write_address;
    logic [COLOR_W-1:0]        o_write_color;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    blit_scoreboard sb;

    // Idle bounds for both sides, changed between phases
    int max_gap_in;
    int max_stall_out;
    // Set by the stimulus to ask the write side for one long hold-off
    int hold_cycles;

    // Screen setting currently programmed, used to aim runs at the edges
    t_quad cur_quad;
    int    cur_ox;
    int    cur_oy;
    int    cur_w;
    int    cur_h;

    rotated_span_blit_addresser #(
        .MAX_RUN(MAX_RUN_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_run_x         (i_run_x),
        .i_run_y         (i_run_y),
        .i_pixel_color   (i_pixel_color),
        .i_run_last      (i_run_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pixel driver: draw a gap, present the beat at the falling edge and
    // hold it until the block takes it at a rising edge. Valid stays high
    // on return so back-to-back beats need no drop in between.
    // ------------------------------------------------------------------
    task automatic send_pixel(logic signed [RUN_W-1:0] run_x,
                              logic signed [RUN_W-1:0] run_y,
                              logic [COLOR_W-1:0] color,
                              logic run_last);
        int gap;
        gap = $urandom_range(0, max_gap_in);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_run_x       <= run_x;
        i_run_y       <= run_y;
        i_pixel_color <= color;
        i_run_last    <= run_last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_pixel(run_x, run_y, color, run_last);
    endtask

    // Drop valid, wait for every predicted write, then let the pipe run dry
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // Program every register while the block is idle. Random junk goes in
    // the bits above each field to make sure the block ignores them, and a
    // write to the unused index sits in the middle of the sequence.
    task automatic program_screen(t_quad q, int ox, int oy, int w, int h, int pitch,
                                  logic [ADDR_W-1:0] base);
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = $urandom;
        reg_write(REG_QUADRANT,      (junk & ~32'h3)    | 32'(q));
        reg_write(REG_OFFSET_X,      (junk & ~32'h3FFF) | (32'(ox) & 32'h3FFF));
        reg_write(REG_OFFSET_Y,      ($urandom & ~32'h3FFF) | (32'(oy) & 32'h3FFF));
        reg_write(REG_NONE,          $urandom);
        reg_write(REG_SCREEN_WIDTH,  ($urandom & ~32'h1FFF) | (32'(w) & 32'h1FFF));
        reg_write(REG_SCREEN_HEIGHT, ($urandom & ~32'h1FFF) | (32'(h) & 32'h1FFF));
        reg_write(REG_LINE_PITCH,    ($urandom & ~32'h3FFF) | (32'(pitch) & 32'h3FFF));
        reg_write(REG_FRAME_BASE,    base);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_quad = q;
        cur_ox   = ox;
        cur_oy   = oy;
        cur_w    = w;
        cur_h    = h;
    endtask

    task automatic pick_random_screen();
        t_quad             q;
        int                ox;
        int                oy;
        int                w;
        int                h;
        int                pitch;
        logic [ADDR_W-1:0] base;
        q = t_quad'($urandom_range(0, 3));
        // small offsets keep most runs reachable; the rest span the full field
        ox = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) - 200
                                         : $urandom_range(0, 16383) - 8192;
        oy = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) - 200
                                         : $urandom_range(0, 16383) - 8192;
        case ($urandom_range(0, 9))
            7:       w = 0;
            8:       w = 4096;
            9:       w = ($urandom_range(0, 1) == 0) ? 1 : 8191;
            default: w = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 9))
            7:       h = 0;
            8:       h = 4096;
            9:       h = ($urandom_range(0, 1) == 0) ? 1 : 8191;
            default: h = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 9))
            6:       pitch = 0;
            7:       pitch = 8192;
            8:       pitch = 16383;
            9:       pitch = $urandom_range(0, 16383);
            default: pitch = $urandom_range(1, 300);
        endcase
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 - $urandom_range(0, 255) : $urandom;
        program_screen(q, ox, oy, w, h, pitch, base);
    endtask

    // Mostly well-formed runs aimed at points across the screen and just past
    // its edges, with some lone noise pixels and some runs that end without the last flag.
    task automatic random_phase(int n_items);
        int sent;
        int kind;
        int len;
        int tx;
        int ty;
        int sx;
        int sy;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                send_pixel(RUN_W'($urandom), RUN_W'($urandom), $urandom, 1'($urandom));
                sent++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 16);
                tx = $urandom_range(0, cur_w + 6) - 3;
                ty = $urandom_range(0, cur_h + 6) - 3;
                // invert the rotation so the run starts near the target
                case (cur_quad)
                    QUAD_0:   begin sx = tx - cur_ox; sy = ty - cur_oy; end
                    QUAD_90:  begin sx = cur_oy - ty; sy = tx - cur_ox; end
                    QUAD_180: begin sx = cur_ox - tx; sy = cur_oy - ty; end
                    default:  begin sx = ty - cur_oy; sy = cur_ox - tx; end
                endcase
                for (int i = 0; i < len; i++)
                    send_pixel(RUN_W'(sx), RUN_W'(sy), $urandom, (i == len - 1) && (kind >= 30));
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Write side: draw a stall per beat, honor a requested long hold, then
    // release and wait for the beat to be taken.
    // ------------------------------------------------------------------
    initial begin
        int w;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, max_stall_out);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Check every write beat taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_write(o_write_address, o_write_color);
    end

    // Watchdog: count cycles with no beat on any channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                    || (o_out_valid === 1'b1 && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_run_x       = '0;
        i_run_y       = '0;
        i_pixel_color = '0;
        i_run_last    = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        hold_cycles   = 0;
        max_gap_in    = MAX_WAIT;
        max_stall_out = MAX_WAIT;
        cur_quad      = QUAD_0;
        cur_ox        = 0;
        cur_oy        = 0;
        cur_w         = 240;
        cur_h         = 240;
        sb = new();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, just off the left, right and top edges, field extremes
        send_pixel(13'sd0, 13'sd0, 32'h0000_0000, 1'b1);
        send_pixel(13'sd239, 13'sd239, 32'hFFFF_FFFF, 1'b1);
        send_pixel(13'sd240, 13'sd0, 32'h1234_5678, 1'b1);
        send_pixel(-13'sd1, 13'sd5, 32'h8765_4321, 1'b1);
        send_pixel(-13'sd4096, -13'sd4096, 32'hA5A5_A5A5, 1'b1);
        send_pixel(13'sd4095, 13'sd4095, 32'h5A5A_5A5A, 1'b1);
        // three-pixel run walking up to the right edge
        send_pixel(13'sd237, 13'sd3, 32'h0000_0001, 1'b0);
        send_pixel(13'sd237, 13'sd3, 32'h0000_0002, 1'b0);
        send_pixel(13'sd237, 13'sd3, 32'h0000_0003, 1'b1);
        send_pixel(13'sd0, -13'sd1, 32'h0000_0004, 1'b1);

        // Each other rotation, placed so the source corner lands on a screen corner
        program_screen(QUAD_90, 0, 239, 240, 240, 240, 32'h0);
        send_pixel(13'sd0, 13'sd0, $urandom, 1'b1);
        send_pixel(13'sd5, 13'sd7, $urandom, 1'b1);
        program_screen(QUAD_180, 239, 239, 240, 240, 240, 32'h0);
        send_pixel(13'sd0, 13'sd0, $urandom, 1'b1);
        send_pixel(13'sd10, 13'sd20, $urandom, 1'b1);
        program_screen(QUAD_270, 239, 0, 240, 240, 240, 32'h0);
        send_pixel(13'sd0, 13'sd0, $urandom, 1'b1);
        send_pixel(13'sd30, 13'sd5, $urandom, 1'b1);

        // Offset extremes with the largest screen; the address wraps past 2^32
        program_screen(QUAD_0, 8191, 8191, 4096, 4096, 8192, 32'hFFFF_FFFF);
        send_pixel(-13'sd4096, -13'sd4096, $urandom, 1'b1);
        send_pixel(-13'sd4095, -13'sd4096, $urandom, 1'b1);
        program_screen(QUAD_0, -8192, -8192, 4096, 4096, 8192, 32'h0);
        send_pixel(13'sd4095, 13'sd4095, $urandom, 1'b1);

        // Zero width, zero height, zero pitch, sizes above the legal range
        program_screen(QUAD_0, 0, 0, 0, 240, 240, 32'h0);
        send_pixel(13'sd0, 13'sd0, $urandom, 1'b1);
        program_screen(QUAD_0, 0, 0, 240, 0, 240, 32'h0);
        send_pixel(13'sd0, 13'sd0, $urandom, 1'b1);
        program_screen(QUAD_0, 0, 0, 240, 240, 0, 32'h0000_1000);
        send_pixel(13'sd5, 13'sd100, $urandom, 1'b1);
        program_screen(QUAD_0, 0, 0, 8191, 8191, 16383, $urandom);
        send_pixel(13'sd4095, 13'sd4095, $urandom, 1'b1);

        // Back-pressure: hold the write side while the sender keeps pushing
        program_screen(QUAD_0, 0, 0, 240, 240, 240, $urandom);
        max_gap_in  = 0;
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 80; i++)
            send_pixel(13'sd10, 13'sd10, $urandom, i == 79);
        // sender pauses here until every write has come out
        settle();

        // Random phases under random screen settings and idle mixes
        for (int p = 0; p < 8; p++) begin
            max_gap_in    = (p % 3 == 0) ? 0 : MAX_WAIT;
            max_stall_out = (p % 4 == 1) ? 0 : MAX_WAIT;
            pick_random_screen();
            random_phase(175);
        end
        settle();

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
